### rtl/vtp_pkg.sv
package vtp_pkg;

  typedef struct packed {
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic signed [23:0] vertex_z;
  } vtp_in_t;

  typedef struct packed {
    logic signed [31:0] pix_x;
    logic signed [31:0] screen_y;
    logic signed [23:0] depth;
  } vtp_out_t;

  typedef enum logic [2:0] {
    REG_ROW_X  = 3'd0,
    REG_ROW_Y  = 3'd1,
    REG_ROW_Z  = 3'd2,
    REG_FOCAL  = 3'd3,
    REG_SCR_W  = 3'd4,
    REG_SCR_H  = 3'd5
  } vtp_reg_t;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;
  localparam int QW = 51;
  localparam int DW = 32;
  localparam int DivSteps = 3;
  localparam int DivStages = (QW + DivSteps - 1) / DivSteps;
  localparam logic signed [31:0] Offscreen = -32'sd32768;

  typedef struct packed {
    logic [63:0] row_x;
    logic [63:0] row_y;
    logic [63:0] row_z;
    logic [9:0]  focal;
    logic [8:0]  scr_w;
    logic [8:0]  scr_h;
  } vtp_cfg_t;

  typedef struct packed {
    logic        neg;
    logic [QW-1:0] rem;
    logic [QW-1:0] num;
    logic [QW-1:0] quo;
  } vtp_div_t;

endpackage

### rtl/vertex_transform_project.sv
// vertex transform and perspective projection, fully pipelined
// input: pulse start with in_data (x, y, z in signed 16.8); busy is always low,
//   so a new vertex transfer can be taken every clock cycle
// config: cfg_we, cfg_idx, cfg_data; registers 0-2 matrix rows, 3 focal,
//   4 screen width, 5 screen height; other indexes are ignored; write only
//   while no vertex is in flight
// output: out_valid strobes for one cycle with out_data; the receiver
//   cannot stall, one result per accepted vertex, in order
// pipeline: matrix product and row sum registers, projection multiply,
//   restoring divider at 3 quotient bits per stage, output register
// throughput: one vertex per cycle, set by the fully staged divider
// reset: rst_n synchronous low clears all valid bits and loads the
//   identity matrix, focal 128, screen 240x160
module vertex_transform_project (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  vtp_pkg::vtp_in_t                  in_data,
  input  logic                              cfg_we,
  input  logic [vtp_pkg::CfgIdxW-1:0]       cfg_idx,
  input  logic [vtp_pkg::CfgDataW-1:0]      cfg_data,
  output logic                              out_valid,
  output vtp_pkg::vtp_out_t                 out_data
);
  import vtp_pkg::*;

  vtp_cfg_t           cfg_r;
  logic               xv;
  logic signed [31:0] cx, cy, cz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_x <= 64'd256;
      cfg_r.row_y <= 64'd1 << 24;
      cfg_r.row_z <= 64'd1 << 40;
      cfg_r.focal <= 10'd128;
      cfg_r.scr_w <= 9'd240;
      cfg_r.scr_h <= 9'd160;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROW_X: cfg_r.row_x <= cfg_data;
        REG_ROW_Y: cfg_r.row_y <= cfg_data;
        REG_ROW_Z: cfg_r.row_z <= cfg_data;
        REG_FOCAL: cfg_r.focal <= cfg_data[9:0];
        REG_SCR_W: cfg_r.scr_w <= cfg_data[8:0];
        REG_SCR_H: cfg_r.scr_h <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  vtp_xform u_xform (
    .clk(clk), .rst_n(rst_n), .in_valid(start), .in_data(in_data), .cfg(cfg_r),
    .out_valid(xv), .cam_x(cx), .cam_y(cy), .cam_z(cz)
  );

  vtp_proj u_proj (
    .clk(clk), .rst_n(rst_n), .in_valid(xv), .cam_x(cx), .cam_y(cy), .cam_z(cz),
    .cfg(cfg_r), .out_valid(out_valid), .out_data(out_data)
  );
endmodule

### rtl/vtp_xform.sv
module vtp_xform (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  vtp_pkg::vtp_in_t     in_data,
  input  vtp_pkg::vtp_cfg_t    cfg,
  output logic                 out_valid,
  output logic signed [31:0]   cam_x,
  output logic signed [31:0]   cam_y,
  output logic signed [31:0]   cam_z
);
  import vtp_pkg::*;

  logic               v1_r, v2_r;
  logic signed [39:0] p_r [3][4];
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [63:0]        rows [3];

  assign rows[0] = cfg.row_x;
  assign rows[1] = cfg.row_y;
  assign rows[2] = cfg.row_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      p_r[r][0] <= 40'(signed'(rows[r][15:0]) * in_data.vertex_x);
      p_r[r][1] <= 40'(signed'(rows[r][31:16]) * in_data.vertex_y);
      p_r[r][2] <= 40'(signed'(rows[r][47:32]) * in_data.vertex_z);
      p_r[r][3] <= 40'(signed'(rows[r][63:48])) <<< 8;
    end
  end

  function automatic logic signed [31:0] rsum(input logic signed [39:0] a, b, c, d);
    logic signed [41:0] s;
    s = 42'(a) + 42'(b) + 42'(c) + 42'(d);
    return s[39:8];
  endfunction

  always_ff @(posedge clk) begin
    cx_r <= rsum(p_r[0][0], p_r[0][1], p_r[0][2], p_r[0][3]);
    cy_r <= rsum(p_r[1][0], p_r[1][1], p_r[1][2], p_r[1][3]);
    cz_r <= rsum(p_r[2][0], p_r[2][1], p_r[2][2], p_r[2][3]);
  end

  assign out_valid = v2_r;
  assign cam_x = cx_r;
  assign cam_y = cy_r;
  assign cam_z = cz_r;
endmodule

### rtl/vtp_div.sv
module vtp_div (
  input  logic            clk,
  input  logic [vtp_pkg::DW-1:0] den,
  input  vtp_pkg::vtp_div_t d_in,
  output vtp_pkg::vtp_div_t d_out
);
  import vtp_pkg::*;

  vtp_div_t st_r [DivStages];
  logic [DW-1:0] den_r [DivStages];

  function automatic vtp_div_t step(input vtp_div_t a, input logic [DW-1:0] dv);
    vtp_div_t b;
    logic [QW:0] t;
    b = a;
    for (int k = 0; k < DivSteps; k++) begin
      t = {b.rem, b.num[QW-1]};
      b.num = b.num << 1;
      if (t >= (QW+1)'(dv)) begin
        b.rem = QW'(t - (QW+1)'(dv));
        b.quo = {b.quo[QW-2:0], 1'b1};
      end else begin
        b.rem = t[QW-1:0];
        b.quo = {b.quo[QW-2:0], 1'b0};
      end
    end
    return b;
  endfunction

  always_ff @(posedge clk) begin
    st_r[0]  <= step(d_in, den);
    den_r[0] <= den;
    for (int i = 1; i < DivStages; i++) begin
      st_r[i]  <= step(st_r[i-1], den_r[i-1]);
      den_r[i] <= den_r[i-1];
    end
  end

  assign d_out = st_r[DivStages-1];
endmodule

### rtl/vtp_proj.sv
module vtp_proj (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [31:0] cam_x,
  input  logic signed [31:0] cam_y,
  input  logic signed [31:0] cam_z,
  input  vtp_pkg::vtp_cfg_t  cfg,
  output logic               out_valid,
  output vtp_pkg::vtp_out_t  out_data
);
  import vtp_pkg::*;

  localparam int Lat = DivStages + 1;

  logic               v_r [Lat+1];
  logic               ok_r [Lat];
  logic signed [31:0] cz_r [Lat];
  logic [QW-1:0]      ax_r, ay_r;
  logic               nx_r, ny_r;
  logic [DW-1:0]      den_r;
  vtp_div_t           dx_out, dy_out, dx_in, dy_in;
  vtp_out_t           o_r;

  logic signed [51:0] mx, my;
  assign mx = 52'(cam_x) * 52'(signed'({1'b0, cfg.focal, 8'd0}));
  assign my = 52'(cam_y) * 52'(signed'({1'b0, cfg.focal, 8'd0}));

  always_ff @(posedge clk) begin
    nx_r  <= mx[51];
    ny_r  <= my[51];
    ax_r  <= mx[51] ? QW'(-mx) : mx[QW-1:0];
    ay_r  <= my[51] ? QW'(-my) : my[QW-1:0];
    den_r <= cam_z;
    ok_r[0] <= cam_z >= 32'sd256;
    cz_r[0] <= cam_z;
    for (int i = 1; i < Lat; i++) begin
      ok_r[i] <= ok_r[i-1];
      cz_r[i] <= cz_r[i-1];
    end
  end

  assign dx_in = '{neg: nx_r, rem: '0, num: ax_r, quo: '0};
  assign dy_in = '{neg: ny_r, rem: '0, num: ay_r, quo: '0};

  vtp_div u_div_x (.clk(clk), .den(den_r), .d_in(dx_in), .d_out(dx_out));
  vtp_div u_div_y (.clk(clk), .den(den_r), .d_in(dy_in), .d_out(dy_out));

  logic signed [QW:0] qx, qy;
  logic signed [31:0] sx, sy;
  always_comb begin
    qx = dx_out.neg ? -(QW+1)'(dx_out.quo) : (QW+1)'(dx_out.quo);
    qy = dy_out.neg ? -(QW+1)'(dy_out.quo) : (QW+1)'(dy_out.quo);
    sx = qx[39:8] + 32'({cfg.scr_w, 7'd0});
    sy = qy[39:8] + 32'({cfg.scr_h, 7'd0});
  end

  always_ff @(posedge clk) begin
    if (ok_r[Lat-1]) begin
      o_r.pix_x    <= sx;
      o_r.screen_y <= sy;
      o_r.depth    <= cz_r[Lat-1][31:8];
    end else begin
      o_r.pix_x    <= Offscreen;
      o_r.screen_y <= Offscreen;
      o_r.depth    <= Offscreen[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= Lat; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int i = 1; i <= Lat; i++) v_r[i] <= v_r[i-1];
    end
  end

  assign out_valid = v_r[Lat];
  assign out_data  = o_r;
endmodule
